// ----- design/bessel_zero_order_series_assert.svh -----
// Assertion macros for the Bessel power series block.
// Included by the RTL file that carries concurrent checks; needs nothing else.
`ifndef BESSEL_ZERO_ORDER_SERIES_ASSERT_SVH
`define BESSEL_ZERO_ORDER_SERIES_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is high.
`define BZS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");
// Clocked check that also holds during reset.
`define BZS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");
`else
`define BZS_ASSERT(lbl, clk, rst, prop)
`define BZS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- design/bzs_pkg.sv -----
// Shared constants and types of the Bessel power series block.
// Used by bzs_mul, bzs_div and bessel_zero_order_series; depends on nothing.
package bzs_pkg;

  localparam int X_W            = 21;   // argument width, Q5.16
  localparam int X_FRAC         = 16;
  localparam int SUM_W          = 46;   // series sum width, Q21.SUM_FRAC_BITS
  localparam int IDX_W          = 7;    // loop index and max_terms width
  localparam int RATIO_INT_W    = 10;
  localparam int RATIO_FRAC_DEF = 32;
  localparam int SUM_FRAC_BITS  = 24;
  localparam int TERM_LIMIT     = 64;

  localparam int MUL_DIG_W  = 16;       // multiplier digit taken per cycle
  localparam int DIV_STEP_W = 8;        // quotient bits produced per cycle

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_TERMS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_ORD_MODE  = 1'b1;

  localparam logic [IDX_W-1:0] MAX_TERMS_RST = 7'd50;
  localparam logic [IDX_W-1:0] TERM_LIMIT_V  = IDX_W'(TERM_LIMIT);

  localparam logic [SUM_W-1:0] SUM_ONE  = SUM_W'(1) << SUM_FRAC_BITS;
  localparam logic [SUM_W-1:0] TERM_SAT = 46'h2000_0000_0000;
  localparam logic signed [SUM_W+1:0] SUM_HI = 48'sh1FFF_FFFF_FFFF;
  localparam logic signed [SUM_W+1:0] SUM_LO = 48'shE000_0000_0000;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ----- design/bzs_mul.sv -----
// Shared iterative multiplier: one MUL_DIG_W-bit digit of b per cycle.
// Depends on bzs_pkg.
module bzs_mul import bzs_pkg::*; #(
  parameter int AW = RATIO_INT_W + RATIO_FRAC_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [AW-1:0]   b,
  output logic [2*AW-1:0] prod,
  output unit_stat_t      stat
);

  localparam int NDIG = (AW + MUL_DIG_W - 1) / MUL_DIG_W;
  localparam int BW   = NDIG * MUL_DIG_W;
  localparam int PW   = 2 * AW;
  localparam int CW   = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic [AW-1:0]           a_reg;
  logic [BW-1:0]           b_reg;
  logic [PW-1:0]           acc;
  logic [CW-1:0]           cnt;
  logic                    busy;
  logic                    done;
  logic [AW+MUL_DIG_W-1:0] pp;
  logic [PW-1:0]           pp_sh;

  assign pp    = a_reg * b_reg[MUL_DIG_W-1:0];
  assign pp_sh = PW'(pp) << (MUL_DIG_W * cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_reg <= a;
        b_reg <= BW'(b);
        acc   <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        acc   <= acc + pp_sh;
        b_reg <= b_reg >> MUL_DIG_W;
        cnt   <= cnt + 1'b1;
        if (cnt == CW'(NDIG - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod      = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- design/bzs_div.sv -----
// Iterative divider by a small index: DIV_STEP_W restoring steps per cycle.
// Depends on bzs_pkg.
module bzs_div import bzs_pkg::*; #(
  parameter int DW = RATIO_INT_W + RATIO_FRAC_DEF + X_W - X_FRAC - 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DW-1:0]    num,
  input  logic [IDX_W-1:0] den,
  output logic [DW-1:0]    quo,
  output unit_stat_t       stat
);

  localparam int NSTEP = (DW + DIV_STEP_W - 1) / DIV_STEP_W;
  localparam int NW    = NSTEP * DIV_STEP_W;
  localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  logic [NW-1:0]         n_reg;
  logic [NW-1:0]         q_reg;
  logic [IDX_W-1:0]      rem;
  logic [IDX_W-1:0]      rem_next;
  logic [IDX_W-1:0]      d_reg;
  logic [DIV_STEP_W-1:0] digit;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic                  done;

  // The remainder stays below the divisor, so it never needs more than IDX_W bits.
  always_comb begin
    logic [IDX_W:0] part;
    rem_next = rem;
    digit    = '0;
    for (int i = 0; i < DIV_STEP_W; i++) begin
      part = {rem_next, n_reg[NW-1-i]};
      if (part >= {1'b0, d_reg}) begin
        part = part - {1'b0, d_reg};
        digit[DIV_STEP_W-1-i] = 1'b1;
      end
      rem_next = part[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n_reg <= NW'(num);
        q_reg <= '0;
        rem   <= '0;
        d_reg <= den;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        n_reg <= n_reg << DIV_STEP_W;
        q_reg <= {q_reg[NW-DIV_STEP_W-1:0], digit};
        rem   <= rem_next;
        cnt   <= cnt + 1'b1;
        if (cnt == CW'(NSTEP - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo       = q_reg[DW-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- design/bessel_zero_order_series.sv -----
// Top level of the zero-order Bessel power series block: sequencer, config
// registers and output register. Depends on bzs_pkg, bzs_mul and bzs_div.
//
// Usage: the argument x (Q5.16) arrives on the s_tvalid/s_tready/s_tdata
// stream; one result beat (sum in Q21.24 and the stopping index) leaves on
// m_tvalid/m_tready/m_tdata for every input beat. max_terms and ordinary_mode
// are written through cfg_we/cfg_addr/cfg_wdata; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Each term takes two passes through the shared digit-serial multiplier
// (NDIG = ceil((10+RATIO_FRAC_BITS)/16) digits each) and one through the
// divider by k (NSTEP = ceil((14+RATIO_FRAC_BITS)/8) steps).
// s_tready is high only while no series is being worked on; the next beat is
// taken as soon as the result sits in the output register, even if the
// receiver has not taken it yet. If the receiver stalls, the finished sum
// waits until m_tready, and the sequencer holds the result in its final state.
// Reset clears the sequencer and the output valid and restores max_terms to
// 50 and ordinary_mode to 0.
`include "bessel_zero_order_series_assert.svh"

module bessel_zero_order_series import bzs_pkg::*; #(
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [20:0] arg_x
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [45:0] bessel_value, [52:46] last_index
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int RW    = RATIO_INT_W + RATIO_FRAC_BITS;
  localparam int PW    = 2 * RW;
  localparam int DW    = RW + X_W - X_FRAC - 1;
  localparam int SQ_SH = 2 * RATIO_FRAC_BITS - SUM_FRAC_BITS;

  localparam logic [RW-1:0] RATIO_ONE = RW'(1) << RATIO_FRAC_BITS;
  localparam logic [RW-1:0] RATIO_MAX = '1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RX_GO    = 4'd1;
  localparam logic [3:0] S_RX_WAIT  = 4'd2;
  localparam logic [3:0] S_DIV_GO   = 4'd3;
  localparam logic [3:0] S_DIV_WAIT = 4'd4;
  localparam logic [3:0] S_SQ_GO    = 4'd5;
  localparam logic [3:0] S_SQ_WAIT  = 4'd6;
  localparam logic [3:0] S_ACC      = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]        state;
  logic [IDX_W-1:0]  max_terms;
  logic              ordinary_mode;
  logic [X_W-1:0]    x_reg;
  logic [RW-1:0]     ratio;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  term;
  logic [IDX_W-1:0]  k_idx;
  logic [IDX_W-1:0]  limit;
  logic [IDX_W-1:0]  limit_next;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  k_plus;

  logic              mul_start;
  logic [RW-1:0]     mul_b;
  logic [PW-1:0]     mul_prod;
  unit_stat_t        mul_stat;
  logic              div_start;
  logic [DW-1:0]     div_quo;
  unit_stat_t        div_stat;

  logic [PW-1:0]     term_full;
  logic [SUM_W-1:0]  term_sat;
  logic [RW-1:0]     ratio_sat;
  logic [SUM_W+1:0]  sum_ext;
  logic [SUM_W+1:0]  term_ext;
  logic signed [SUM_W+1:0] s_wide;
  logic [SUM_W-1:0]  sum_next;

  assign s_tready  = (state == S_IDLE);
  assign mul_start = (state == S_RX_GO) || (state == S_SQ_GO);
  assign mul_b     = (state == S_SQ_GO) ? ratio : RW'(x_reg);
  assign div_start = (state == S_DIV_GO);

  bzs_mul #(.AW(RW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (ratio),
    .b     (mul_b),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  // The division by 2k splits into a fixed shift of the product and the divider by k.
  bzs_div #(.DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mul_prod[RW+X_W-1:X_FRAC+1]),
    .den   (k_idx),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  assign limit_next = (max_terms > TERM_LIMIT_V) ? TERM_LIMIT_V : max_terms;
  assign ratio_sat  = (|div_quo[DW-1:RW]) ? RATIO_MAX : div_quo[RW-1:0];
  assign term_full  = mul_prod >> SQ_SH;
  assign term_sat   = (term_full > PW'(TERM_SAT)) ? TERM_SAT : term_full[SUM_W-1:0];
  assign k_plus     = k_idx + 1'b1;

  assign sum_ext  = {{2{sum[SUM_W-1]}}, sum};
  assign term_ext = {2'b00, term};
  assign s_wide   = (ordinary_mode && k_idx[0]) ? $signed(sum_ext) - $signed(term_ext)
                                                : $signed(sum_ext) + $signed(term_ext);

  always_comb begin
    if (s_wide > SUM_HI) begin
      sum_next = SUM_HI[SUM_W-1:0];
    end else if (s_wide < SUM_LO) begin
      sum_next = SUM_LO[SUM_W-1:0];
    end else begin
      sum_next = s_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_terms     <= MAX_TERMS_RST;
      ordinary_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_TERMS: max_terms     <= cfg_wdata;
        REG_ORD_MODE:  ordinary_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // A new result may replace the one being taken in the same cycle.
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            x_reg <= s_tdata[X_W-1:0];
            ratio <= RATIO_ONE;
            sum   <= SUM_ONE;
            k_idx <= IDX_W'(1);
            limit <= limit_next;
            if (limit_next > IDX_W'(1)) begin
              state <= S_RX_GO;
            end else begin
              last_idx <= IDX_W'(1);
              state    <= S_DONE;
            end
          end
        end
        S_RX_GO:  state <= S_RX_WAIT;
        S_RX_WAIT: begin
          if (mul_stat.done) begin
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_stat.done) begin
            ratio <= ratio_sat;
            state <= S_SQ_GO;
          end
        end
        S_SQ_GO:  state <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (mul_stat.done) begin
            term  <= term_sat;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          sum <= sum_next;
          // A term that truncates to zero ends the series after it is added.
          if (term == '0) begin
            last_idx <= k_idx;
            state    <= S_DONE;
          end else if (k_plus >= limit) begin
            last_idx <= k_plus;
            state    <= S_DONE;
          end else begin
            k_idx <= k_plus;
            state <= S_RX_GO;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {{(OUT_TDATA_W - SUM_W - IDX_W){1'b0}}, last_idx, sum};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BZS_ASSERT(a_units_idle, clk, rst, (state == S_IDLE) |-> (!mul_stat.busy && !div_stat.busy))
  `BZS_ASSERT(a_mul_done_wait, clk, rst, mul_stat.done |-> (state == S_RX_WAIT || state == S_SQ_WAIT))
  `BZS_ASSERT(a_div_done_wait, clk, rst, div_stat.done |-> (state == S_DIV_WAIT))
  `BZS_ASSERT(a_index_range, clk, rst, (state == S_RX_GO) |-> (k_idx != '0 && k_idx < limit))
  `BZS_ASSERT(a_term_to_acc, clk, rst, (state == S_SQ_WAIT && mul_stat.done) |=> (state == S_ACC))

endmodule
